/* rtl/pidc_pkg.sv */
// Shared widths, register indexes, reset values and sequencer states of the PID controller.
`default_nettype none

package pidc_pkg;

  localparam int unsigned DataW   = 32;  // setpoint, angle, gains, period, drive
  localparam int unsigned ErrW    = 33;  // setpoint minus angle, exact
  localparam int unsigned DiffW   = 34;  // error difference
  localparam int unsigned IntegW  = 48;  // integral, Q32.16
  localparam int unsigned DerivW  = 50;  // error difference times sample rate
  localparam int unsigned RateW   = 16;
  localparam int unsigned LimitW  = 31;
  localparam int unsigned AccW    = 84;  // holds the exact three-term sum
  localparam int unsigned FracW   = 16;
  localparam int unsigned QuotW   = AccW - FracW;
  localparam int unsigned CntW    = 5;   // bit counter of the shift-add unit
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegKp     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKi     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKd     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPeriod = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRate   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLimit  = 3'd5;

  localparam logic [DataW-1:0]  KpReset     = 32'd19660800;
  localparam logic [DataW-1:0]  KiReset     = 32'd52429;
  localparam logic [DataW-1:0]  KdReset     = 32'd2818048;
  localparam logic [DataW-1:0]  PeriodReset = 32'd4294967;
  localparam logic [RateW-1:0]  RateReset   = 16'd1000;
  localparam logic [LimitW-1:0] LimitReset  = 31'd13107200;

  localparam logic [CntW-1:0] LastGainBit = 5'd31;
  localparam logic [CntW-1:0] LastRateBit = 5'd15;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP,
    ST_INTEG,
    ST_DERIV,
    ST_KP,
    ST_KI,
    ST_KD,
    ST_DONE
  } pidc_state_t;

endpackage

`default_nettype wire

/* rtl/pidc_ifs.sv */
// Valid/ready channel interfaces of the PID controller: tick input, result output, config writes.
`default_nettype none

interface pidc_tick_if
  import pidc_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] setpoint;
  logic [DataW-1:0] measured_angle;

  modport source (output valid, output setpoint, output measured_angle, input ready);
  modport sink   (input valid, input setpoint, input measured_angle, output ready);
endinterface

interface pidc_result_if
  import pidc_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] drive;
  logic             clamped;

  modport source (output valid, output drive, output clamped, input ready);
  modport sink   (input valid, input drive, input clamped, output ready);
endinterface

interface pidc_cfg_if
  import pidc_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DataW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/pid_controller_clamped_top.sv */
// PID controller with clamped output, built around one bit-serial shift-add multiplier.
`default_nettype none

// One tick in, one result out. All five products (|error| times period, error difference
// times rate, and the three gain terms) go through a single shift-add unit that retires
// one multiplier bit per cycle. A tick runs the integral step, the integral update, the
// derivative and then the three gain terms; the first tick after reset skips the integral
// and derivative updates. The next tick is taken in idle, which the block enters as the
// result is loaded into the output register; a result waiting there does not hold up the
// next tick's arithmetic. Drive is the Q32.32 sum floored to Q16.16 and clamped to
// +/- output_limit, with clamped set whenever the limit was applied. The integral
// saturates at 48 bits. Configuration writes are taken only while the block is idle with
// no result waiting, and win over a tick offered in the same cycle.
module pid_controller_clamped_top
  import pidc_pkg::*;
  (
    input  wire          clk,
    input  wire          rst,
    pidc_cfg_if.sink     cfg,
    pidc_tick_if.sink    tick,
    pidc_result_if.source result
  );

  // configuration
  logic [DataW-1:0]  kp_gain, ki_gain, kd_gain, sample_period;
  logic [RateW-1:0]  sample_rate;
  logic [LimitW-1:0] output_limit;

  // controller state
  pidc_state_t state, state_next;
  logic                     primed, primed_next;
  logic signed [ErrW-1:0]   err, err_next;
  logic signed [ErrW-1:0]   prev_err, prev_err_next;
  logic signed [IntegW-1:0] integ, integ_next;
  logic signed [DerivW-1:0] deriv, deriv_next;

  // shift-add unit
  logic [AccW-1:0]  acc, acc_next;
  logic [AccW-1:0]  opnd, opnd_next;
  logic [DataW-1:0] mbits, mbits_next;
  logic [CntW-1:0]  cnt, cnt_next;
  logic [AccW-1:0]  mac_sum;

  // output register
  logic             res_valid, res_valid_next;
  logic [DataW-1:0] res_drive, res_drive_next;
  logic             res_clamped, res_clamped_next;

  logic signed [ErrW-1:0]   err_in;
  logic [DataW-1:0]         err_mag;
  logic signed [DiffW-1:0]  diff;
  logic [DataW-1:0]         step;
  logic signed [IntegW:0]   integ_sum;
  logic signed [QuotW-1:0]  quot;
  logic signed [QuotW-1:0]  limit_wide;
  logic                     over_hi, over_lo;
  logic                     slot_free;

  // registers change only when no tick is in flight
  assign cfg.ready = (state == ST_IDLE) && !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain       <= KpReset;
      ki_gain       <= KiReset;
      kd_gain       <= KdReset;
      sample_period <= PeriodReset;
      sample_rate   <= RateReset;
      output_limit  <= LimitReset;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        RegKp:     kp_gain       <= cfg.data;
        RegKi:     ki_gain       <= cfg.data;
        RegKd:     kd_gain       <= cfg.data;
        RegPeriod: sample_period <= cfg.data;
        RegRate:   sample_rate   <= cfg.data[RateW-1:0];
        RegLimit:  output_limit  <= cfg.data[LimitW-1:0];
        default: ;
      endcase
    end
  end

  assign err_in = $signed({tick.setpoint[DataW-1], tick.setpoint})
                - $signed({tick.measured_angle[DataW-1], tick.measured_angle});
  // |error| never exceeds 2^32 - 1
  assign err_mag = err_in[ErrW-1] ? DataW'(-err_in) : err_in[DataW-1:0];
  assign diff    = $signed({err[ErrW-1], err}) - $signed({prev_err[ErrW-1], prev_err});
  assign step    = acc[2*DataW-1:DataW];
  assign integ_sum = $signed({integ[IntegW-1], integ})
                   + (err[ErrW-1] ? -$signed({{(IntegW+1-DataW){1'b0}}, step})
                                  :  $signed({{(IntegW+1-DataW){1'b0}}, step}));

  assign mac_sum = acc + (mbits[0] ? opnd : '0);

  // floor(sum / 2^16) against the limit
  assign quot       = $signed(acc[AccW-1:FracW]);
  assign limit_wide = $signed({{(QuotW-LimitW){1'b0}}, output_limit});
  assign over_hi    = quot > limit_wide;
  assign over_lo    = quot < -limit_wide;
  assign slot_free  = !res_valid || result.ready;

  assign tick.ready     = (state == ST_IDLE) && !cfg.valid;
  assign result.valid   = res_valid;
  assign result.drive   = res_drive;
  assign result.clamped = res_clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      primed    <= 1'b0;
      prev_err  <= '0;
      integ     <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      primed    <= primed_next;
      prev_err  <= prev_err_next;
      integ     <= integ_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    err         <= err_next;
    deriv       <= deriv_next;
    acc         <= acc_next;
    opnd        <= opnd_next;
    mbits       <= mbits_next;
    cnt         <= cnt_next;
    res_drive   <= res_drive_next;
    res_clamped <= res_clamped_next;
  end

  always_comb begin
    state_next       = state;
    primed_next      = primed;
    err_next         = err;
    prev_err_next    = prev_err;
    integ_next       = integ;
    deriv_next       = deriv;
    acc_next         = acc;
    opnd_next        = opnd;
    mbits_next       = mbits;
    cnt_next         = cnt;
    res_valid_next   = res_valid && !result.ready;
    res_drive_next   = res_drive;
    res_clamped_next = res_clamped;

    unique case (state)
      ST_IDLE: begin
        if (tick.valid && tick.ready) begin
          err_next = err_in;
          acc_next = '0;
          cnt_next = LastGainBit;
          if (primed) begin
            opnd_next  = {{(AccW-DataW){1'b0}}, err_mag};
            mbits_next = sample_period;
            state_next = ST_STEP;
          end else begin
            deriv_next = '0;
            opnd_next  = {{(AccW-ErrW){err_in[ErrW-1]}}, err_in};
            mbits_next = kp_gain;
            state_next = ST_KP;
          end
        end
      end

      ST_STEP, ST_DERIV, ST_KP, ST_KI, ST_KD: begin
        acc_next   = mac_sum;
        opnd_next  = opnd << 1;
        mbits_next = mbits >> 1;
        cnt_next   = cnt - 1'b1;
        if (cnt == '0) begin
          cnt_next = LastGainBit;
          unique case (state)
            ST_STEP: begin
              state_next = ST_INTEG;
            end
            ST_DERIV: begin
              deriv_next = $signed(mac_sum[DerivW-1:0]);
              acc_next   = '0;
              opnd_next  = {{(AccW-ErrW){err[ErrW-1]}}, err};
              mbits_next = kp_gain;
              state_next = ST_KP;
            end
            ST_KP: begin
              opnd_next  = {{(AccW-IntegW){integ[IntegW-1]}}, integ};
              mbits_next = ki_gain;
              state_next = ST_KI;
            end
            ST_KI: begin
              opnd_next  = {{(AccW-DerivW){deriv[DerivW-1]}}, deriv};
              mbits_next = kd_gain;
              state_next = ST_KD;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end

      ST_INTEG: begin
        // saturate on 48-bit overflow
        if (integ_sum[IntegW] != integ_sum[IntegW-1]) begin
          integ_next = integ_sum[IntegW] ? {1'b1, {(IntegW-1){1'b0}}}
                                         : {1'b0, {(IntegW-1){1'b1}}};
        end else begin
          integ_next = integ_sum[IntegW-1:0];
        end
        acc_next   = '0;
        opnd_next  = {{(AccW-DiffW){diff[DiffW-1]}}, diff};
        mbits_next = {{(DataW-RateW){1'b0}}, sample_rate};
        cnt_next   = LastRateBit;
        state_next = ST_DERIV;
      end

      ST_DONE: begin
        if (slot_free) begin
          res_valid_next   = 1'b1;
          res_clamped_next = over_hi || over_lo;
          if (over_hi) begin
            res_drive_next = {1'b0, output_limit};
          end else if (over_lo) begin
            res_drive_next = ~{1'b0, output_limit} + 1'b1;
          end else begin
            res_drive_next = quot[DataW-1:0];
          end
          prev_err_next = err;
          primed_next   = 1'b1;
          state_next    = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // a clamped result sits exactly on one of the limits
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.clamped |->
      (result.drive == {1'b0, output_limit}) || (result.drive == ~{1'b0, output_limit} + 1'b1))
    else $error("clamped drive is not at the limit");

  // an unclamped result lies within the limits
  assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.clamped |->
      ($signed(result.drive) <= $signed({1'b0, output_limit})) &&
      ($signed(result.drive) >= -$signed({1'b0, output_limit})))
    else $error("unclamped drive outside the limit");

  // a tick transfer starts the integral step once primed, else the proportional term
  assert property (@(posedge clk) disable iff (rst)
    tick.valid && tick.ready |=>
      ($past(primed) && state == ST_STEP) || (!$past(primed) && state == ST_KP))
    else $error("tick transfer started the wrong phase");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the clamped PID controller: directed and random ticks.
`timescale 1ns / 1ps

module tb_top;
  import pidc_pkg::*;

  localparam int WatchdogLimit = 2000;  // cycles without any transfer
  localparam int ClosingCycles = 200;
  localparam int RandomPhases  = 10;
  localparam int PhaseItems    = 150;

  // indexes past the register list; writes there must be ignored
  localparam logic [CfgIdxW-1:0] RegSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpare7 = 3'd7;

  localparam longint IntegMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint IntegMin = -IntegMax - 1;

  typedef enum int {
    PROF_GENTLE,
    PROF_MAXIMA,
    PROF_RANDOM,
    PROF_MINIMA,
    PROF_DEFAULT
  } profile_t;

  typedef struct packed {
    logic [DataW-1:0] drive;
    logic             clamped;
  } drive_t;

  class drive_checker;
    logic [DataW-1:0]  kp, ki, kd, period;
    logic [RateW-1:0]  rate;
    logic [LimitW-1:0] limit;
    longint            last_err;
    longint            integ;
    bit                primed;
    drive_t            expected_q[$];
    int                errors;

    function new();
      kp       = KpReset;
      ki       = KiReset;
      kd       = KdReset;
      period   = PeriodReset;
      rate     = RateReset;
      limit    = LimitReset;
      last_err = 0;
      integ    = 0;
      primed   = 1'b0;
      errors   = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] data);
      case (idx)
        RegKp:     kp = data;
        RegKi:     ki = data;
        RegKd:     kd = data;
        RegPeriod: period = data;
        RegRate:   rate = data[RateW-1:0];
        RegLimit:  limit = data[LimitW-1:0];
        default: ;
      endcase
    endfunction

    // unsigned gain times signed value, exact
    function logic signed [127:0] gain_product(logic [DataW-1:0] g, longint v);
      logic signed [127:0] a, b;
      a = $signed({96'd0, g});
      b = v;
      return a * b;
    endfunction

    function void note_tick(logic [DataW-1:0] sp, logic [DataW-1:0] ms);
      longint              err, step, next_integ, deriv;
      logic [63:0]         mag, prod;
      logic signed [127:0] sum, floored, lim;
      drive_t              want;
      err   = longint'($signed(sp)) - longint'($signed(ms));
      deriv = 0;
      if (primed) begin
        mag  = (err < 0) ? -err : err;
        prod = mag * {32'd0, period};
        step = longint'(prod >> 32);   // magnitude truncated, sign restored below
        next_integ = integ + ((err < 0) ? -step : step);
        if (next_integ > IntegMax) next_integ = IntegMax;
        else if (next_integ < IntegMin) next_integ = IntegMin;
        integ = next_integ;
        deriv = (err - last_err) * longint'({48'd0, rate});
      end
      sum = gain_product(kp, err) + gain_product(ki, integ) + gain_product(kd, deriv);
      floored = sum >>> FracW;
      lim = $signed({97'd0, limit});
      if (floored > lim) begin
        want.drive   = {1'b0, limit};
        want.clamped = 1'b1;
      end else if (floored < -lim) begin
        want.drive   = 32'd0 - {1'b0, limit};
        want.clamped = 1'b1;
      end else begin
        want.drive   = floored[DataW-1:0];
        want.clamped = 1'b0;
      end
      last_err = err;
      primed   = 1'b1;
      expected_q.push_back(want);
    endfunction

    function void check_drive(logic [DataW-1:0] drive, logic clamped);
      drive_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: drive %h clamped %b", $time, drive, clamped);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (drive !== want.drive) begin
        $display("%0t: drive expected %h, actual %h", $time, want.drive, drive);
        errors++;
      end
      if (clamped !== want.clamped) begin
        $display("%0t: clamped expected %b, actual %b", $time, want.clamped, clamped);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   calm;   // no idling on either side

  pidc_cfg_if    cfg_ch ();
  pidc_tick_if   tick_ch ();
  pidc_result_if res_ch ();

  pid_controller_clamped_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .tick   (tick_ch),
    .result (res_ch)
  );

  drive_checker sb;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: ready drops in bursts and always comes back high in between
  initial begin
    int hold;
    hold = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        hold = hold - 1;
        res_ch.ready <= (hold == 0);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 7);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // results are checked before the tick of the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (res_ch.valid && res_ch.ready) sb.check_drive(res_ch.drive, res_ch.clamped);
      if (tick_ch.valid && tick_ch.ready)
        sb.note_tick(tick_ch.setpoint, tick_ch.measured_angle);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((cfg_ch.valid && cfg_ch.ready) || (tick_ch.valid && tick_ch.ready) ||
          (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet = quiet + 1;
    end
    $display("Mismatches found");
    $finish;
  end

  function automatic int pick_gap();
    if (calm || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 7);
  endfunction

  function automatic logic [DataW-1:0] pick_edge();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  task automatic send_tick(input logic [DataW-1:0] sp, input logic [DataW-1:0] ms);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      tick_ch.valid <= 1'b0;
      // sometimes hold back until the block is waiting for the next tick
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk); while (!tick_ch.ready);
      end
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid          <= 1'b1;
    tick_ch.setpoint       <= sp;
    tick_ch.measured_angle <= ms;
    do @(posedge clk); while (!tick_ch.ready);
  endtask

  // stop sending and wait until every tick has produced its result
  task automatic end_phase();
    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic write_set(input logic [DataW-1:0] kp, input logic [DataW-1:0] ki,
                           input logic [DataW-1:0] kd, input logic [DataW-1:0] per,
                           input logic [DataW-1:0] rate_word,
                           input logic [DataW-1:0] limit_word);
    cfg_write(RegKp, kp);
    cfg_write(RegKi, ki);
    cfg_write(RegKd, kd);
    cfg_write(($urandom_range(0, 1) == 1) ? RegSpare6 : RegSpare7, $urandom);
    cfg_write(RegPeriod, per);
    cfg_write(RegRate, rate_word);
    cfg_write(RegLimit, limit_word);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_profile(input profile_t prof);
    case (prof)
      PROF_GENTLE:
        write_set($urandom_range(0, 32'h2_0000), $urandom_range(0, 32'h1000),
                  $urandom_range(0, 32'h400), $urandom, $urandom_range(1, 64),
                  $urandom_range(32'h10_0000, 32'h7FFF_FFFF));
      PROF_MAXIMA:
        write_set(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'h0000_FFFF, 32'h7FFF_FFFF);
      PROF_RANDOM:
        write_set($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      PROF_MINIMA:
        write_set(32'd0, $urandom, 32'd0, 32'd1, 32'd1, 32'd0);
      default:
        write_set(KpReset, KiReset, KdReset, PeriodReset, {16'd0, RateReset},
                  {1'b0, LimitReset});
    endcase
  endtask

  task automatic run_random(input int count);
    logic [DataW-1:0] sp, ms;
    int               base;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          sp = $urandom;
          ms = $urandom;
        end
        8: begin
          sp = pick_edge();
          ms = pick_edge();
        end
        9: begin
          sp = $urandom;
          ms = sp;
        end
        default: begin
          // small error: the angle lies within -4096 to +4095 of the setpoint
          base = int'($urandom_range(0, 32'h7FFFF)) - 262144;
          sp   = base;
          ms   = base + int'($urandom_range(0, 8191)) - 4096;
        end
      endcase
      send_tick(sp, ms);
    end
    end_phase();
  endtask

  initial begin
    sb = new();
    calm = 1'b0;
    rst <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= RegKp;
    cfg_ch.data <= '0;
    tick_ch.valid <= 1'b0;
    tick_ch.setpoint <= '0;
    tick_ch.measured_angle <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset gains; the first tick leaves integral and derivative at zero
    send_tick(32'h7FFF_FFFF, 32'h8000_0000);
    send_tick(32'h8000_0000, 32'h7FFF_FFFF);
    send_tick(32'h0000_0000, 32'h0000_0000);
    send_tick(32'h0000_4000, 32'h0000_3F00);
    send_tick(32'h0000_4000, 32'h0000_4000);
    send_tick(32'hFFFF_FFFF, 32'h0000_0001);
    end_phase();

    // unity kp: drive equals error, probe both clamp edges
    write_set(32'h0001_0000, 32'd0, 32'd0, PeriodReset, {16'd0, RateReset}, 32'h0005_0000);
    send_tick(32'h0005_0000, 32'h0000_0000);
    send_tick(32'h0005_0001, 32'h0000_0000);
    send_tick(32'h0000_0000, 32'h0005_0000);
    send_tick(32'h0000_0000, 32'h0005_0001);
    end_phase();

    // half kp and half period: floor rounding and truncated integral steps
    write_set(32'h0000_8000, 32'h0001_0000, 32'd0, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF);
    send_tick(32'h0000_0000, 32'h0000_0001);
    send_tick(32'h0000_0000, 32'h0000_0003);
    send_tick(32'h0000_0003, 32'h0000_0000);
    send_tick(32'h0000_0001, 32'h0000_0000);
    end_phase();

    // zero period, zero rate, zero limit
    write_set(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
    send_tick($urandom, $urandom);
    send_tick($urandom, $urandom);
    send_tick(32'h0000_0005, 32'h0000_0005);
    end_phase();

    for (int p = 0; p < RandomPhases; p++) begin
      calm = (p == RandomPhases - 1) || ($urandom_range(0, 3) == 0);
      apply_profile(profile_t'((p + 1) % 5));
      run_random(PhaseItems);
    end

    repeat (ClosingCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
